// File: rtl/mck_pkg.sv
package mck_pkg;

	// register indexes on the configuration port
	localparam logic [2:0] REG_DOT_ON       = 3'd0;
	localparam logic [2:0] REG_DASH_ON      = 3'd1;
	localparam logic [2:0] REG_ELEMENT_GAP  = 3'd2;
	localparam logic [2:0] REG_WORD_GAP     = 3'd3;
	localparam logic [2:0] REG_LETTER_GAP   = 3'd4;

	// reset values of the duration registers
	localparam logic [15:0] RST_DOT_ON      = 16'd500;
	localparam logic [15:0] RST_DASH_ON     = 16'd1500;
	localparam logic [15:0] RST_ELEMENT_GAP = 16'd200;
	localparam logic [15:0] RST_WORD_GAP    = 16'd600;
	localparam logic [15:0] RST_LETTER_GAP  = 16'd200;

	// recognized character codes
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;

	localparam int NUM_LETTERS = 26;

	// element count per letter, a to z
	localparam logic [2:0] PAT_LEN [NUM_LETTERS] = '{
		3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
		3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
	};

	// element bits per letter, first element in the top used bit, 1 is a dash
	localparam logic [3:0] PAT_BITS [NUM_LETTERS] = '{
		4'h1, 4'h8, 4'hA, 4'h4, 4'h0, 4'h2, 4'h6, 4'h0, 4'h0, 4'h7, 4'h5, 4'h4, 4'h3,
		4'h2, 4'h7, 4'h6, 4'hD, 4'h2, 4'h0, 4'h1, 4'h1, 4'h1, 4'h3, 4'h9, 4'hB, 4'hC
	};

	typedef enum logic [1:0] {
		KIND_OTHER,
		KIND_SPACE,
		KIND_LETTER
	} char_kind_t;

	// classified character as it waits in the queue
	typedef struct packed {
		char_kind_t kind;
		logic [2:0] len;
		logic [3:0] bits;
	} char_desc_t;

	// duration registers
	typedef struct packed {
		logic [15:0] dot_on_ms;
		logic [15:0] dash_on_ms;
		logic [15:0] element_gap_ms;
		logic [15:0] word_gap_ms;
		logic [15:0] letter_gap_ms;
	} dur_cfg_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MARK,
		BK_ELEM_GAP,
		BK_WORD_GAP,
		BK_LETTER_GAP
	} bk_state_t;

	// sort one character code into letter, space or other
	function automatic char_desc_t classify(input logic [7:0] code);
		char_desc_t d;
		logic [7:0] offs;
		logic [4:0] idx;
		offs = code - CHAR_LOWER_A;
		idx  = offs[4:0];
		d.kind = KIND_OTHER;
		d.len  = 3'd0;
		d.bits = 4'h0;
		if (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z) begin
			d.kind = KIND_LETTER;
			d.len  = PAT_LEN[idx];
			d.bits = PAT_BITS[idx];
		end else if (code == CHAR_SPACE) begin
			d.kind = KIND_SPACE;
		end
		return d;
	endfunction

endpackage

// File: rtl/mck_front.sv
module mck_front
	import mck_pkg::*;
(
	input  logic       start,
	input  logic [7:0] char_code,
	input  logic       q_full,
	output logic       busy,
	output logic       push,
	output char_desc_t push_desc
);

	// take an item whenever the queue has room
	assign busy = q_full;
	assign push = start & ~q_full;

	// pattern lookup for the accepted character
	assign push_desc = classify(char_code);

endmodule

// File: rtl/mck_queue.sv
module mck_queue
	import mck_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  char_desc_t push_desc,
	input  logic       pop,
	output char_desc_t pop_desc,
	output logic       full,
	output logic       empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	char_desc_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_desc = mem_q[rd_ptr_q];

	// storage, written at the tail
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/mck_back.sv
module mck_back
	import mck_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  dur_cfg_t    cfg,
	input  logic        q_empty,
	input  char_desc_t  q_desc,
	output logic        pop,
	output logic        strobe,
	output logic        light_on,
	output logic [15:0] duration_ms,
	output logic        last_segment
);

	bk_state_t  state_q, state_d;
	char_desc_t desc_q, desc_d;
	logic [1:0] elem_q, elem_d;
	logic [1:0] dash_idx;
	logic [2:0] len_m1;
	logic       load;

	// position of the current element within the pattern bits
	assign len_m1   = desc_q.len - 3'd1;
	assign dash_idx = len_m1[1:0] - elem_q;

	// segment sequencer
	always_comb begin
		state_d      = state_q;
		desc_d       = desc_q;
		elem_d       = elem_q;
		load         = 1'b0;
		pop          = 1'b0;
		strobe       = 1'b0;
		light_on     = 1'b0;
		duration_ms  = cfg.letter_gap_ms;
		last_segment = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				load = 1'b1;
			end
			BK_MARK: begin
				strobe      = 1'b1;
				light_on    = 1'b1;
				duration_ms = desc_q.bits[dash_idx] ? cfg.dash_on_ms : cfg.dot_on_ms;
				state_d     = BK_ELEM_GAP;
			end
			BK_ELEM_GAP: begin
				strobe      = 1'b1;
				duration_ms = cfg.element_gap_ms;
				if ({1'b0, elem_q} == len_m1) begin
					state_d = BK_LETTER_GAP;
				end else begin
					elem_d  = elem_q + 2'd1;
					state_d = BK_MARK;
				end
			end
			BK_WORD_GAP: begin
				strobe      = 1'b1;
				duration_ms = cfg.word_gap_ms;
				state_d     = BK_LETTER_GAP;
			end
			BK_LETTER_GAP: begin
				strobe       = 1'b1;
				last_segment = 1'b1;
				state_d      = BK_IDLE;
				load         = 1'b1;
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase

		// pick up the next item while idle or during the closing letter gap
		if (load && !q_empty) begin
			pop    = 1'b1;
			desc_d = q_desc;
			elem_d = 2'd0;
			unique case (q_desc.kind)
				KIND_LETTER: state_d = BK_MARK;
				KIND_SPACE:  state_d = BK_WORD_GAP;
				default:     state_d = BK_LETTER_GAP;
			endcase
		end
	end

	// current item
	always_ff @(posedge clk) begin
		desc_q <= desc_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			elem_q  <= 2'd0;
		end else begin
			state_q <= state_d;
			elem_q  <= elem_d;
		end
	end

	// the closing segment of an item is always dark
	a_last_dark: assert property (@(posedge clk) disable iff (!arst_n)
		last_segment |-> strobe && !light_on)
		else $error("last segment not an off segment");

	// every mark is followed right away by its element gap
	a_mark_then_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && light_on |=> strobe && !light_on && !last_segment)
		else $error("mark not followed by element gap");

	// element counter stays inside the letter
	a_elem_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_MARK || state_q == BK_ELEM_GAP) |->
			({1'b0, elem_q} < desc_q.len))
		else $error("element index beyond pattern length");

	// no item is taken from an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("pop from empty queue");

endmodule

// File: rtl/morse_character_keyer.sv
// Morse character keyer
// Input: one character code per item on start/char_code. An item is taken at a
// clock edge where start is high and busy is low. Lowercase a to z are keyed as
// dots and dashes, a space gives a word gap, anything else only a letter gap.
// Output: one segment per cycle on strobe with light_on, duration_ms and
// last_segment; last_segment marks the closing letter gap of each item. The
// receiver cannot stall, so segments leave every cycle while work is pending.
// An accepted item is queued, then popped into the sequencer's item and state
// registers before its first segment. Throughput: one segment per cycle, so an
// item gives 2n+1 segments for a letter of n elements (3 to 9), 2 for a space
// and 1 for any other code; the next waiting item is taken during the closing
// letter gap of the one before. A queue of QUEUE_DEPTH classified items sits
// between input and sequencer; busy is high only while it is full.
// Configuration: wr_en/wr_index/wr_data write the five duration registers
// (dot, dash, element gap, word gap, letter gap); indexes above four are
// ignored. Writes are meant for idle periods only.
// Reset: arst_n clears the queue and sequencer and loads the default durations.
module morse_character_keyer
	import mck_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  char_code,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [15:0] wr_data,
	output logic        strobe,
	output logic        light_on,
	output logic [15:0] duration_ms,
	output logic        last_segment
);

	dur_cfg_t   cfg_q;
	logic       push;
	char_desc_t push_desc;
	logic       q_full;
	logic       q_empty;
	logic       pop;
	char_desc_t pop_desc;

	// duration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dot_on_ms      <= RST_DOT_ON;
			cfg_q.dash_on_ms     <= RST_DASH_ON;
			cfg_q.element_gap_ms <= RST_ELEMENT_GAP;
			cfg_q.word_gap_ms    <= RST_WORD_GAP;
			cfg_q.letter_gap_ms  <= RST_LETTER_GAP;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_DOT_ON:      cfg_q.dot_on_ms      <= wr_data;
				REG_DASH_ON:     cfg_q.dash_on_ms     <= wr_data;
				REG_ELEMENT_GAP: cfg_q.element_gap_ms <= wr_data;
				REG_WORD_GAP:    cfg_q.word_gap_ms    <= wr_data;
				REG_LETTER_GAP:  cfg_q.letter_gap_ms  <= wr_data;
				default: ;
			endcase
		end
	end

	// accept and classify
	mck_front u_front (
		.start     (start),
		.char_code (char_code),
		.q_full    (q_full),
		.busy      (busy),
		.push      (push),
		.push_desc (push_desc)
	);

	// classified items waiting for the sequencer
	mck_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.pop_desc  (pop_desc),
		.full      (q_full),
		.empty     (q_empty)
	);

	// segment sequencer
	mck_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_empty      (q_empty),
		.q_desc       (pop_desc),
		.pop          (pop),
		.strobe       (strobe),
		.light_on     (light_on),
		.duration_ms  (duration_ms),
		.last_segment (last_segment)
	);

endmodule
